>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the output driver checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define OTLD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define OTLD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/otld_pkg.sv
// ----------------------------------------------------------------------------
// otld_pkg
// Types, codes and constants shared by the on-time limited output driver.
// ----------------------------------------------------------------------------
`default_nettype none

package otld_pkg;

   // field and register widths
   localparam int unsigned OPCODE_W   = 2;
   localparam int unsigned DURATION_W = 16;
   localparam int unsigned STAGE_W    = 3;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // register reset values
   localparam logic              OUTPUT_PRESENT_RST = 1'b1;
   localparam logic [TIME_W-1:0] MAX_ON_MS_RST      = 32'd15000;
   localparam logic [TIME_W-1:0] MIN_OFF_MS_RST     = 32'd5000;

   // overheat handling
   localparam logic [DURATION_W-1:0] OVERHEAT_RUN_MS = 16'd6000;
   localparam logic [STAGE_W-1:0]    STAGE_CLEAR     = 3'd0;
   localparam logic [STAGE_W-1:0]    STAGE_VENT      = 3'd4;

   // item opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STAGE = 2'd2
   } opcode_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTPUT_PRESENT = 2'd0,
      CSR_MAX_ON_MS      = 2'd1,
      CSR_MIN_OFF_MS     = 2'd2
   } csr_index_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic              output_present;
      logic [TIME_W-1:0] max_on_ms;
      logic [TIME_W-1:0] min_off_ms;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic drive_on;
      logic off_event;
   } result_type;

endpackage

`default_nettype wire

>>> sv/otld_csr.sv
// ----------------------------------------------------------------------------
// otld_csr
// Configuration registers of the output driver, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module otld_csr
   import otld_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   output      cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OUTPUT_PRESENT: cfg_in.output_present = csr_wr_data[0];
            CSR_MAX_ON_MS:      cfg_in.max_on_ms      = csr_wr_data[TIME_W-1:0];
            CSR_MIN_OFF_MS:     cfg_in.min_off_ms     = csr_wr_data[TIME_W-1:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_present <= OUTPUT_PRESENT_RST;
         cfg_ff.max_on_ms      <= MAX_ON_MS_RST;
         cfg_ff.min_off_ms     <= MIN_OFF_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/otld_core.sv
// ----------------------------------------------------------------------------
// otld_core
// Driver state and the single-pass update for one item: counters, start/stop.
// ----------------------------------------------------------------------------
`default_nettype none

module otld_core
   import otld_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [OPCODE_W-1:0]   opcode,
   input  wire logic [DURATION_W-1:0] duration_ms,
   input  wire logic [STAGE_W-1:0]    stage,
   input  wire cfg_type               cfg,
   output      result_type            result
);

   logic                  is_on_ff,       is_on_in;
   logic [TIME_W-1:0]     on_elapsed_ff,  on_elapsed_in;
   logic [TIME_W-1:0]     off_elapsed_ff, off_elapsed_in;
   logic [DURATION_W-1:0] run_length_ff,  run_length_in;

   logic                  off_ev;
   logic [TIME_W-1:0]     on_inc;
   logic [TIME_W-1:0]     off_inc;
   logic                  can_stop;
   logic                  can_start;
   logic                  rest_done;
   logic                  run_expired;
   logic                  max_reached;
   logic [DURATION_W-1:0] start_len;
   logic                  do_start;
   logic                  do_stop;

   // saturating tick counters
   assign on_inc  = (on_elapsed_ff == '1)  ? on_elapsed_ff  : on_elapsed_ff + 32'd1;
   assign off_inc = (off_elapsed_ff == '1) ? off_elapsed_ff : off_elapsed_ff + 32'd1;

   // limit and rest comparisons
   assign can_stop    = cfg.output_present && is_on_ff;
   assign can_start   = cfg.output_present && !is_on_ff;
   assign rest_done   = off_elapsed_ff >= cfg.min_off_ms;
   assign run_expired = (run_length_ff != '0) &&
                        (on_inc >= {{(TIME_W-DURATION_W){1'b0}}, run_length_ff});
   assign max_reached = on_inc >= cfg.max_on_ms;

   // opcode decode into start and stop requests
   always_comb begin
      do_start  = 1'b0;
      do_stop   = 1'b0;
      start_len = duration_ms;
      unique case (opcode)
         OP_TICK:  do_stop = run_expired || max_reached;
         OP_START: do_start = 1'b1;
         OP_STAGE: begin
            if (stage == STAGE_CLEAR) begin
               do_stop = 1'b1;
            end else if (stage == STAGE_VENT) begin
               do_start  = 1'b1;
               start_len = OVERHEAT_RUN_MS;
            end
         end
         default:  do_start = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      is_on_in       = is_on_ff;
      on_elapsed_in  = on_elapsed_ff;
      off_elapsed_in = off_elapsed_ff;
      run_length_in  = run_length_ff;
      off_ev         = 1'b0;
      if (opcode == OP_TICK) begin
         on_elapsed_in  = on_inc;
         off_elapsed_in = off_inc;
      end
      if (do_stop && can_stop) begin
         is_on_in       = 1'b0;
         off_elapsed_in = '0;
         run_length_in  = '0;
         off_ev         = 1'b1;
      end
      if (do_start && can_start) begin
         run_length_in = start_len;
         if (rest_done) begin
            is_on_in      = 1'b1;
            on_elapsed_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_on_ff       <= 1'b0;
         on_elapsed_ff  <= '0;
         off_elapsed_ff <= '0;
         run_length_ff  <= '0;
      end else if (step) begin
         is_on_ff       <= is_on_in;
         on_elapsed_ff  <= on_elapsed_in;
         off_elapsed_ff <= off_elapsed_in;
         run_length_ff  <= run_length_in;
      end
   end

   assign result.drive_on  = is_on_in;
   assign result.off_event = off_ev;

endmodule

`default_nettype wire

>>> sv/on_time_limited_output_driver.sv
// Output driver with on-time limits: each transfer in is a 1 ms tick, a start
// request or an overheat stage report, and yields exactly one transfer out with
// the output level and an off event flag. The block takes one item per cycle
// while req_stall is low; an item enters an input register, the counters and
// limit compares run in one pass, and the result lands in an output register.
// A stalled output register holds the next item in the input register and
// stalls the input side only when both are full. Req stall is high during
// reset. Configuration writes take effect at the next edge.
// ----------------------------------------------------------------------------
// on_time_limited_output_driver
// Top level: input register, driver core, result register and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module on_time_limited_output_driver
   import otld_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // item input
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [OPCODE_W-1:0]   req_opcode,
   input  wire logic [DURATION_W-1:0] req_duration_ms,
   input  wire logic [STAGE_W-1:0]    req_stage,
   // result output
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_drive_on,
   output      logic                  rsp_off_event,
   // configuration writes
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic                  s1_valid_ff,    s1_valid_in;
   logic [OPCODE_W-1:0]   s1_opcode_ff;
   logic [DURATION_W-1:0] s1_duration_ff;
   logic [STAGE_W-1:0]    s1_stage_ff;
   logic                  rsp_valid_ff,   rsp_valid_in;
   result_type            rsp_result_ff;

   logic       req_fire;
   logic       out_load;
   logic       s1_adv;
   cfg_type    cfg;
   result_type result;

   // handshake control
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_load;
   assign req_stall = reset || (s1_valid_ff && !out_load);
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   assign rsp_valid_in = out_load ? s1_adv : rsp_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_opcode_ff   <= req_opcode;
         s1_duration_ff <= req_duration_ms;
         s1_stage_ff    <= req_stage;
      end
   end

   // configuration registers
   otld_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // driver state and item update
   otld_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_adv),
      .opcode      (s1_opcode_ff),
      .duration_ms (s1_duration_ff),
      .stage       (s1_stage_ff),
      .cfg         (cfg),
      .result      (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_on  = rsp_result_ff.drive_on;
   assign rsp_off_event = rsp_result_ff.off_event;

endmodule

`default_nettype wire

>>> sv/otld_checker.sv
// ----------------------------------------------------------------------------
// otld_checker
// Port-level checks of the output driver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module otld_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_drive_on,
   input wire logic rsp_off_event
);

   // a stalled result stays offered and unchanged
   `OTLD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drive_on) && $stable(rsp_off_event), "stalled result changed")

   // an off event always reports the output as off
   `OTLD_ASSERT_IMP(a_off_level, clock, reset, rsp_valid && rsp_off_event, !rsp_drive_on, "off event with output on")

   // a result appears only after a matching transfer in
   `OTLD_ASSERT_IMP(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without matching transfer in")

   // the input side never stalls while the result side is empty
   `OTLD_ASSERT_IMP(a_no_idle_stall, clock, reset, !rsp_valid, !req_stall, "input stalled with empty output")

endmodule

bind on_time_limited_output_driver otld_checker u_otld_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_drive_on  (rsp_drive_on),
   .rsp_off_event (rsp_off_event)
);

`default_nettype wire
